// ===== rtl/core/rkme_pkg.sv =====
// Package with the widths, register indexes and counter reduction helpers of the knob editor.
package rkme_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int RANGE_W  = COUNT_W + 1;
    localparam int VALUE_W  = 10;
    localparam int LOCK_W   = 16;
    localparam int DETENT_W = 4;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_ENTRIES_DEFAULT = 8;

    // Counter reduction runs over COUNT_W shift positions, a few per pipeline stage.
    localparam int MOD_STEPS_PER_STAGE = 4;
    localparam int MOD_STAGES = COUNT_W / MOD_STEPS_PER_STAGE;
    localparam int MOD_K_W = $clog2(COUNT_W);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_VALUE_MIN     = 3'd0;
    localparam t_cfg_idx CFG_VALUE_MAX     = 3'd1;
    localparam t_cfg_idx CFG_LOCKOUT_MS    = 3'd2;
    localparam t_cfg_idx CFG_DETENT_COUNTS = 3'd3;
    localparam t_cfg_idx CFG_COUNT_TOP     = 3'd4;

    localparam logic [VALUE_W-1:0]  RST_VALUE_MIN     = 10'd0;
    localparam logic [VALUE_W-1:0]  RST_VALUE_MAX     = 10'd999;
    localparam logic [LOCK_W-1:0]   RST_LOCKOUT_MS    = 16'd200;
    localparam logic [DETENT_W-1:0] RST_DETENT_COUNTS = 4'd4;
    localparam logic [COUNT_W-1:0]  RST_COUNT_TOP     = 16'd1000;
    localparam logic [VALUE_W-1:0]  RST_ENTRY_VALUE   = 10'd50;

    // One restoring step: subtract the range shifted left by k when it fits.
    function automatic logic [COUNT_W-1:0] mod_step(
        input logic [COUNT_W-1:0] rem,
        input logic [RANGE_W-1:0] range,
        input logic [MOD_K_W-1:0] k
    );
        logic [RANGE_W+COUNT_W-1:0] dv;
        logic [RANGE_W+COUNT_W-1:0] rv;
        dv = (RANGE_W+COUNT_W)'(range) << k;
        rv = (RANGE_W+COUNT_W)'(rem);
        if (rv >= dv) begin
            rv = rv - dv;
        end
        return rv[COUNT_W-1:0];
    endfunction

    // A group of restoring steps from shift position k_hi downward.
    function automatic logic [COUNT_W-1:0] mod_steps(
        input logic [COUNT_W-1:0] rem,
        input logic [RANGE_W-1:0] range,
        input int                 k_hi
    );
        logic [COUNT_W-1:0] r;
        r = rem;
        for (int i = 0; i < MOD_STEPS_PER_STAGE; i++) begin
            r = mod_step(r, range, MOD_K_W'(k_hi - i));
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rkme_poll_if.sv =====
// Channel interface for poll beats into the knob editor.
interface rkme_poll_if
    import rkme_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  time_ms;
    logic               button_edge;
    logic [COUNT_W-1:0] encoder_count;

    modport source (output valid, output time_ms, output button_edge, output encoder_count,
                    input ready);
    modport sink (input valid, input time_ms, input button_edge, input encoder_count,
                  output ready);
endinterface

// ===== rtl/core/rkme_result_if.sv =====
// Channel interface for result beats out of the knob editor.
interface rkme_result_if
    import rkme_pkg::*;
#(
    parameter int CW = 3
);
    logic               valid;
    logic               ready;
    logic               edit_active;
    logic [CW-1:0]      selected_entry;
    logic [VALUE_W-1:0] selected_value;
    logic               changed;

    modport source (output valid, output edit_active, output selected_entry,
                    output selected_value, output changed, input ready);
    modport sink (input valid, input edit_active, input selected_entry,
                  input selected_value, input changed, output ready);
endinterface

// ===== rtl/core/rotary_knob_menu_editor_unit.sv =====
// Top level of the rotary knob menu editor: poll pipeline, menu state and result register.
// The block takes one poll beat per cycle while its input stage is free and no base reduction
// pass runs. The beat is captured in an input register, four stages reduce the counter value
// modulo count_top + 1, and the menu state is updated as the beat enters the output register.
// A write to count_top starts a pass that reduces the stored detent base under the new range,
// one shift position per cycle; ready stays low while the pass runs.
module rotary_knob_menu_editor_unit
    import rkme_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT,
    parameter int CW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  t_cfg_idx             i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    rkme_poll_if.sink            i_poll,
    rkme_result_if.source        o_result
);

    localparam int NS = MOD_STAGES + 1;
    localparam logic [CW:0] LAST_ENTRY = (CW+1)'(NUM_ENTRIES - 1);

    logic [VALUE_W-1:0]  r_value_min;
    logic [VALUE_W-1:0]  r_value_max;
    logic [LOCK_W-1:0]   r_lockout_ms;
    logic [DETENT_W-1:0] r_detent_counts;
    logic [COUNT_W-1:0]  r_count_top;

    logic [VALUE_W-1:0]  r_entry [NUM_ENTRIES];
    logic [CW-1:0]       r_cursor;
    logic                r_mode_edit;
    logic [COUNT_W-1:0]  r_base_raw;
    logic [COUNT_W-1:0]  r_base_red;
    logic [TIME_W-1:0]   r_last_press;

    logic                r_bm_busy;
    logic [MOD_K_W-1:0]  r_bm_k;

    logic                r_vld   [NS];
    logic [TIME_W-1:0]   r_time  [NS];
    logic                r_edge  [NS];
    logic [COUNT_W-1:0]  r_count [NS];

    logic                r_ov;
    logic                r_o_edit;
    logic [CW-1:0]       r_o_entry;
    logic [VALUE_W-1:0]  r_o_value;
    logic                r_o_changed;

    logic                s_go   [NS];
    logic                s_free [NS];
    logic                out_free;
    logic                in_acc;
    logic [RANGE_W-1:0]  w_range;

    logic                n_mode_edit;
    logic [CW-1:0]       n_cursor;
    logic [VALUE_W-1:0]  n_value;
    logic                n_value_we;
    logic                n_take;
    logic                n_press;
    logic                n_changed;
    logic [VALUE_W-1:0]  n_out_value;

    assign w_range  = {1'b0, r_count_top} + RANGE_W'(1);
    assign out_free = !r_ov || o_result.ready;

    always_comb begin
        for (int i = NS - 1; i >= 0; i--) begin
            if (i == NS - 1) begin
                s_go[i] = r_vld[i] && out_free;
            end else begin
                s_go[i] = r_vld[i] && s_free[i+1];
            end
            s_free[i] = !r_vld[i] || s_go[i];
        end
    end

    assign i_poll.ready = s_free[0] && !r_bm_busy;
    assign in_acc       = i_poll.valid && i_poll.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_min     <= RST_VALUE_MIN;
            r_value_max     <= RST_VALUE_MAX;
            r_lockout_ms    <= RST_LOCKOUT_MS;
            r_detent_counts <= RST_DETENT_COUNTS;
            r_count_top     <= RST_COUNT_TOP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_VALUE_MIN:     r_value_min     <= i_cfg_wdata[VALUE_W-1:0];
                CFG_VALUE_MAX:     r_value_max     <= i_cfg_wdata[VALUE_W-1:0];
                CFG_LOCKOUT_MS:    r_lockout_ms    <= i_cfg_wdata[LOCK_W-1:0];
                CFG_DETENT_COUNTS: r_detent_counts <= i_cfg_wdata[DETENT_W-1:0];
                CFG_COUNT_TOP:     r_count_top     <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= in_acc ? 1'b1 : (s_go[0] ? 1'b0 : r_vld[0]);
            for (int i = 1; i < NS; i++) begin
                r_vld[i] <= s_go[i-1] ? 1'b1 : (s_go[i] ? 1'b0 : r_vld[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time[0]  <= i_poll.time_ms;
            r_edge[0]  <= i_poll.button_edge;
            r_count[0] <= i_poll.encoder_count;
        end
        for (int i = 1; i < NS; i++) begin
            if (s_go[i-1]) begin
                r_time[i]  <= r_time[i-1];
                r_edge[i]  <= r_edge[i-1];
                r_count[i] <= mod_steps(r_count[i-1], w_range,
                                        COUNT_W - 1 - (i - 1) * MOD_STEPS_PER_STAGE);
            end
        end
    end

    always_comb begin
        logic [TIME_W-1:0]         elapsed;
        logic [COUNT_W-1:0]        cnt;
        logic [RANGE_W-1:0]        diff;
        logic [RANGE_W-1:0]        d;
        logic [RANGE_W-1:0]        mag;
        logic                      up;
        logic [DETENT_W-1:0]       need;
        logic signed [VALUE_W+1:0] v;
        logic [VALUE_W-1:0]        cur_value;
        logic [VALUE_W-1:0]        old_value;

        elapsed = r_time[NS-1] - r_last_press;
        n_press = r_edge[NS-1] && (elapsed > TIME_W'(r_lockout_ms));
        n_mode_edit = r_mode_edit ^ n_press;

        cnt  = r_count[NS-1];
        diff = {1'b0, cnt} - {1'b0, r_base_red};
        d    = diff[RANGE_W-1] ? diff + w_range : diff;
        up   = ({d, 1'b0} <= {1'b0, w_range});
        mag  = up ? d : w_range - d;
        need = (r_detent_counts == '0) ? DETENT_W'(1) : r_detent_counts;
        n_take = (d != '0) && (mag >= RANGE_W'(need));

        n_cursor = r_cursor;
        if (n_take && !n_mode_edit) begin
            if (up && (({1'b0, r_cursor} + (CW+1)'(1)) <= LAST_ENTRY)) begin
                n_cursor = r_cursor + CW'(1);
            end else if (!up && (r_cursor != '0)) begin
                n_cursor = r_cursor - CW'(1);
            end
        end

        old_value = r_entry[r_cursor];
        cur_value = r_entry[n_cursor];
        v = $signed({2'b00, cur_value}) + (up ? (VALUE_W+2)'(1) : -(VALUE_W+2)'(1));
        if (v < $signed({2'b00, r_value_min})) begin
            v = $signed({2'b00, r_value_min});
        end
        if (v > $signed({2'b00, r_value_max})) begin
            v = $signed({2'b00, r_value_max});
        end
        if (v < 0) begin
            v = '0;
        end
        n_value    = v[VALUE_W-1:0];
        n_value_we = n_take && n_mode_edit;

        n_out_value = n_value_we ? n_value : cur_value;
        n_changed = (n_mode_edit != r_mode_edit) || (n_cursor != r_cursor) ||
                    (n_out_value != old_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_entry[i] <= RST_ENTRY_VALUE;
            end
            r_cursor     <= '0;
            r_mode_edit  <= 1'b0;
            r_base_raw   <= '0;
            r_base_red   <= '0;
            r_last_press <= '0;
            r_bm_busy    <= 1'b0;
            r_bm_k       <= '0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == CFG_COUNT_TOP)) begin
                r_bm_busy  <= 1'b1;
                r_bm_k     <= MOD_K_W'(COUNT_W - 1);
                r_base_red <= r_base_raw;
            end else if (r_bm_busy) begin
                r_base_red <= mod_step(r_base_red, w_range, r_bm_k);
                r_bm_k     <= r_bm_k - MOD_K_W'(1);
                if (r_bm_k == '0) begin
                    r_bm_busy <= 1'b0;
                end
            end else if (s_go[NS-1]) begin
                if (n_take) begin
                    r_base_raw <= r_count[NS-1];
                    r_base_red <= r_count[NS-1];
                end
            end
            if (s_go[NS-1]) begin
                r_mode_edit <= n_mode_edit;
                r_cursor    <= n_cursor;
                if (n_press) begin
                    r_last_press <= r_time[NS-1];
                end
                if (n_value_we) begin
                    r_entry[n_cursor] <= n_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go[NS-1]) begin
            r_o_edit    <= n_mode_edit;
            r_o_entry   <= n_cursor;
            r_o_value   <= n_out_value;
            r_o_changed <= n_changed;
        end
    end

    assign o_result.valid          = r_ov;
    assign o_result.edit_active    = r_o_edit;
    assign o_result.selected_entry = r_o_entry;
    assign o_result.selected_value = r_o_value;
    assign o_result.changed        = r_o_changed;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bm_busy |-> !i_poll.ready)
        else $error("Poll accepted during the base reduction pass.");

    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_bm_busy && !$past(i_cfg_wr_en && (i_cfg_index == CFG_COUNT_TOP)))
            |-> ({1'b0, r_base_red} < w_range))
        else $error("Reduced detent base is not below the counter range.");

    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cursor} <= LAST_ENTRY))
        else $error("Cursor points past the last entry.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_go[NS-1] |=> r_ov)
        else $error("A beat left the pipeline without reaching the output register.");

endmodule
